// ----- hdl/fpfa_pkg.sv -----
// Package for the fixed-partition fit allocator.
// Holds the sizing constants, the operation, status and policy codes, the result struct
// and the saturating total helper. It depends on nothing.
package fpfa_pkg;

  // Table and field sizing.
  localparam int MAX_PARTITIONS = 16;
  localparam int SIZE_BITS      = 16;
  localparam int IDX_BITS       = $clog2(MAX_PARTITIONS);
  localparam int CNT_BITS       = $clog2(MAX_PARTITIONS + 1);
  localparam int TOTAL_BITS     = 20;
  localparam int INDEX_W        = 4;
  localparam int LEFT_W         = 16;
  localparam int FIELD_W        = 16;
  localparam int ACC_BITS       = (CNT_BITS + SIZE_BITS > TOTAL_BITS + 1) ?
                                  (CNT_BITS + SIZE_BITS) : (TOTAL_BITS + 1);

  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_ADD     = 2'd1;
  localparam logic [1:0] OP_ALLOC   = 2'd2;
  localparam logic [1:0] OP_RELEASE = 2'd3;

  // Status codes of a result transaction.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_NO_FIT = 2'd2;

  // Allocation policies; the unused code behaves as first fit.
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // One result transaction.
  typedef struct packed {
    logic [1:0]            status;
    logic [INDEX_W-1:0]    partition_index;
    logic [LEFT_W-1:0]     leftover;
    logic [TOTAL_BITS-1:0] internal_total;
    logic [TOTAL_BITS-1:0] external_total;
  } fpfa_result_t;

  // Clamp a wide sum to the largest total value.
  function automatic logic [TOTAL_BITS-1:0] sat_total(input logic [ACC_BITS-1:0] value);
    logic [TOTAL_BITS-1:0] clamped;
    if (value > ACC_BITS'(TOTAL_MAX)) begin
      clamped = TOTAL_MAX;
    end else begin
      clamped = value[TOTAL_BITS-1:0];
    end
    return clamped;
  endfunction

endpackage

// ----- hdl/fpfa_size_ram.sv -----
// Partition size memory: one write port and one read port with registered read data.
// Depends on fpfa_pkg for the depth and the entry width.
module fpfa_size_ram (
  input  logic                          clk,
  input  logic                          write_en,
  input  logic [fpfa_pkg::IDX_BITS-1:0]  write_addr,
  input  logic [fpfa_pkg::SIZE_BITS-1:0] write_data,
  input  logic                          read_en,
  input  logic [fpfa_pkg::IDX_BITS-1:0]  read_addr,
  output logic [fpfa_pkg::SIZE_BITS-1:0] read_data
);
  import fpfa_pkg::*;

  logic [SIZE_BITS-1:0] mem [MAX_PARTITIONS];

  // Write port.
  always_ff @(posedge clk) begin
    if (write_en) begin
      mem[write_addr] <= write_data;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (read_en) begin
      read_data <= mem[read_addr];
    end
  end

endmodule

// ----- hdl/fpfa_engine.sv -----
// Allocation engine: sequencer, taken flags, totals and the scan over the size memory.
// Depends on fpfa_pkg and instantiates fpfa_size_ram.
module fpfa_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 operation,
  input  logic [fpfa_pkg::FIELD_W-1:0] size_value,
  input  logic [1:0]                 policy,
  output logic                       res_valid,
  output fpfa_pkg::fpfa_result_t     res,
  input  logic                       res_take
);
  import fpfa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ADD    = 5'b00010,
    S_SCAN   = 5'b00100,
    S_FINISH = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t                state;
  logic [1:0]            op;
  logic [SIZE_BITS-1:0]  req;
  logic [SIZE_BITS-1:0]  lim;
  logic [CNT_BITS-1:0]   count;
  logic [MAX_PARTITIONS-1:0] taken;
  logic [TOTAL_BITS-1:0] leftover_sum;
  logic [SIZE_BITS-1:0]  largest;
  logic                  failed;
  logic                  add_full;
  logic [CNT_BITS-1:0]   rd_idx;
  logic                  rd_valid;
  logic [IDX_BITS-1:0]   rd_entry;
  logic                  have_pick;
  logic [IDX_BITS-1:0]   pick_idx;
  logic [SIZE_BITS-1:0]  pick_size;
  logic [ACC_BITS-1:0]   acc;

  logic                  ram_we;
  logic                  ram_re;
  logic [SIZE_BITS-1:0]  ram_rdata;
  logic [SIZE_BITS-1:0]  size_in;
  logic                  entry_free;
  logic                  entry_fits;
  logic                  entry_better;
  logic                  is_best;
  logic                  is_worst;
  logic [SIZE_BITS-1:0]  left_val;
  logic [ACC_BITS-1:0]   sum_grown;
  logic [ACC_BITS-1:0]   pick_corr;
  logic [ACC_BITS-1:0]   ext_grant;

  assign size_in   = size_value[SIZE_BITS-1:0];
  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_DONE);
  assign is_best   = (policy == POL_BEST);
  assign is_worst  = (policy == POL_WORST);

  // The size memory is written on an add and read once per entry during a scan.
  assign ram_we = (state == S_ADD) && (count < CNT_BITS'(MAX_PARTITIONS));
  assign ram_re = (state == S_SCAN) && (rd_idx < count);

  fpfa_size_ram u_size_ram (
    .clk        (clk),
    .write_en   (ram_we),
    .write_addr (count[IDX_BITS-1:0]),
    .write_data (req),
    .read_en    (ram_re),
    .read_addr  (rd_idx[IDX_BITS-1:0]),
    .read_data  (ram_rdata)
  );

  // Judge the entry returned by the memory against the request and the current pick.
  always_comb begin
    entry_free = !taken[rd_entry];
    entry_fits = entry_free && (ram_rdata >= req) && (op == OP_ALLOC);
    if (is_best) begin
      entry_better = (ram_rdata < pick_size);
    end else if (is_worst) begin
      entry_better = (ram_rdata > pick_size);
    end else begin
      entry_better = 1'b0;
    end
  end

  // Grant arithmetic used when the scan has finished.
  always_comb begin
    left_val  = pick_size - req;
    sum_grown = ACC_BITS'(leftover_sum) + ACC_BITS'(left_val);
    pick_corr = (pick_size < lim) ? ACC_BITS'(pick_size) : '0;
    ext_grant = acc - pick_corr;
  end

  // Sequencer and state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      taken        <= '0;
      leftover_sum <= '0;
      largest      <= '0;
      failed       <= 1'b0;
      rd_valid     <= 1'b0;
    end else begin
      rd_valid <= ram_re;
      rd_entry <= rd_idx[IDX_BITS-1:0];

      // Fold each entry read into the pick and the fragmentation sum.
      if (rd_valid) begin
        if (entry_free && (ram_rdata < lim)) begin
          acc <= acc + ACC_BITS'(ram_rdata);
        end
        if (entry_fits && (!have_pick || entry_better)) begin
          have_pick <= 1'b1;
          pick_idx  <= rd_entry;
          pick_size <= ram_rdata;
        end
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op        <= operation;
            req       <= size_in;
            lim       <= ((operation == OP_ALLOC) && (size_in > largest)) ? size_in : largest;
            rd_idx    <= '0;
            acc       <= '0;
            have_pick <= 1'b0;
            if (operation == OP_ADD) begin
              state <= S_ADD;
            end else if (operation == OP_ALLOC) begin
              state <= S_SCAN;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_ADD: begin
          add_full <= !ram_we;
          if (ram_we) begin
            taken[count[IDX_BITS-1:0]] <= 1'b0;
            count <= count + CNT_BITS'(1);
          end
          state <= failed ? S_SCAN : S_FINISH;
        end
        S_SCAN: begin
          if (ram_re) begin
            rd_idx <= rd_idx + CNT_BITS'(1);
          end else begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // Each arm sets every result field exactly once.
          case (op)
            OP_CLEAR: begin
              count               <= '0;
              taken               <= '0;
              leftover_sum        <= '0;
              largest             <= '0;
              failed              <= 1'b0;
              res.status          <= ST_OK;
              res.partition_index <= '0;
              res.leftover        <= '0;
              res.internal_total  <= '0;
              res.external_total  <= '0;
            end
            OP_RELEASE: begin
              taken               <= '0;
              leftover_sum        <= '0;
              largest             <= '0;
              failed              <= 1'b0;
              res.status          <= ST_OK;
              res.partition_index <= '0;
              res.leftover        <= '0;
              res.internal_total  <= '0;
              res.external_total  <= '0;
            end
            OP_ADD: begin
              res.status          <= add_full ? ST_FULL : ST_OK;
              res.partition_index <= '0;
              res.leftover        <= '0;
              res.internal_total  <= leftover_sum;
              res.external_total  <= failed ? sat_total(acc) : '0;
            end
            OP_ALLOC: begin
              largest <= lim;
              if (have_pick) begin
                taken[pick_idx]     <= 1'b1;
                leftover_sum        <= sat_total(sum_grown);
                res.status          <= ST_OK;
                res.partition_index <= INDEX_W'(pick_idx);
                res.leftover        <= LEFT_W'(left_val);
                res.internal_total  <= sat_total(sum_grown);
                res.external_total  <= failed ? sat_total(ext_grant) : '0;
              end else begin
                failed              <= 1'b1;
                res.status          <= ST_NO_FIT;
                res.partition_index <= '0;
                res.leftover        <= '0;
                res.internal_total  <= leftover_sum;
                res.external_total  <= sat_total(acc);
              end
            end
            default: begin
              res.status          <= ST_OK;
              res.partition_index <= '0;
              res.leftover        <= '0;
              res.internal_total  <= leftover_sum;
              res.external_total  <= '0;
            end
          endcase
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/fixed_partition_fit_allocator.sv -----
// Fixed-partition fit allocator top level: policy register, engine and output register.
// Depends on fpfa_pkg and instantiates fpfa_engine.
// An allocate scans every loaded partition; an add writes one entry and, once some request
// has failed, also scans; a clear or a release goes straight to the result.
// The engine takes no new transaction until its result has moved to the output register.
// Reset empties the table, zeroes all totals and selects first fit; sizes are not cleared.
module fixed_partition_fit_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [15:0] size_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [3:0]  partition_index,
  output logic [15:0] leftover,
  output logic [19:0] internal_total,
  output logic [19:0] external_total
);
  import fpfa_pkg::*;

  logic         fit_policy;
  logic [1:0]   policy;
  logic         res_valid;
  logic         res_take;
  fpfa_result_t res;

  // Policy register.
  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POL_FIRST;
    end else if (cfg_write) begin
      policy <= cfg_data;
    end
  end

  assign fit_policy = (policy != POL_FIRST);

  fpfa_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .size_value (size_value),
    .policy     (policy),
    .res_valid  (res_valid),
    .res        (res),
    .res_take   (res_take)
  );

  // The output register frees the engine while a result waits for the consumer.
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      status          <= res.status;
      partition_index <= res.partition_index;
      leftover        <= res.leftover;
      internal_total  <= res.internal_total;
      external_total  <= res.external_total;
    end
  end

  // An accepted transaction keeps the input side busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again right after a transaction");

  // A refused add or request reports no index and no leftover.
  a_refusal_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL || status == ST_NO_FIT) |->
      partition_index == '0 && leftover == '0)
    else $error("refusal carries an index or a leftover");

  // A nonzero leftover is always counted in the running internal total.
  a_leftover_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK && leftover != '0 |-> internal_total != '0)
    else $error("leftover missing from internal total");

  // Whether a policy other than first fit is selected changes in flight only after a write.
  a_policy_quiet: assert property (@(posedge clk) disable iff (rst)
    in_stall && !res_valid |=> fit_policy == $past(fit_policy) || $past(cfg_write))
    else $error("policy changed without a write");

endmodule
